FILE: rtl/kuwahara_filter_macros.svh
// Assertion macros used by the checker file of the Kuwahara filter.
`ifndef KUWAHARA_FILTER_MACROS_SVH
`define KUWAHARA_FILTER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define KF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kuwahara_filter check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define KF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kuwahara_filter check failed");

`endif

FILE: rtl/kf_pkg.sv
// Shared types and constants of the Kuwahara filter.
package kf_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_W_W    = 12;
  localparam int CFG_H_W    = 13;
  localparam int CFG_R_W    = 4;
  localparam int CHAN_W     = 8;
  localparam int PIXEL_W    = 4 * CHAN_W;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_ALPHA = 2'd3;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_VMUL,
    ST_VCMP,
    ST_DIV,
    ST_OUT
  } kf_state_t;

  typedef struct packed {
    logic accept;
    logic scan_init;
    logic issue;
    logic var_mul;
    logic var_cmp;
    logic div_step;
    logic load_out;
  } kf_cmd_t;

  typedef struct packed {
    logic out_ready;
    logic tap_last;
    logic pipe_busy;
    logic q_last;
    logic div_last;
    logic out_free;
  } kf_sts_t;

endpackage

FILE: rtl/kf_ram.sv
// Generic simple dual-port RAM with registered read data.
module kf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/kf_ctrl.sv
// Controller state machine of the Kuwahara filter.
module kf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  kf_pkg::kf_sts_t sts,
  output kf_pkg::kf_cmd_t cmd,
  output logic            idle
);

  kf_pkg::kf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kf_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = kf_pkg::ST_CHECK;
      end
      kf_pkg::ST_CHECK: begin
        state_nxt = sts.out_ready ? kf_pkg::ST_SCAN : kf_pkg::ST_IDLE;
      end
      kf_pkg::ST_SCAN: begin
        if (sts.tap_last) state_nxt = kf_pkg::ST_DRAIN;
      end
      kf_pkg::ST_DRAIN: begin
        if (!sts.pipe_busy) state_nxt = kf_pkg::ST_VMUL;
      end
      kf_pkg::ST_VMUL: begin
        state_nxt = kf_pkg::ST_VCMP;
      end
      kf_pkg::ST_VCMP: begin
        state_nxt = sts.q_last ? kf_pkg::ST_DIV : kf_pkg::ST_SCAN;
      end
      kf_pkg::ST_DIV: begin
        if (sts.div_last) state_nxt = kf_pkg::ST_OUT;
      end
      kf_pkg::ST_OUT: begin
        if (sts.out_free) state_nxt = kf_pkg::ST_IDLE;
      end
      default: state_nxt = kf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    idle = 1'b0;
    unique case (state_r)
      kf_pkg::ST_IDLE: begin
        idle       = 1'b1;
        cmd.accept = in_valid;
      end
      kf_pkg::ST_CHECK: cmd.scan_init = sts.out_ready;
      kf_pkg::ST_SCAN:  cmd.issue     = 1'b1;
      kf_pkg::ST_DRAIN: ;
      kf_pkg::ST_VMUL:  cmd.var_mul   = 1'b1;
      kf_pkg::ST_VCMP:  cmd.var_cmp   = 1'b1;
      kf_pkg::ST_DIV:   cmd.div_step  = 1'b1;
      kf_pkg::ST_OUT:   cmd.load_out  = sts.out_free;
      default: ;
    endcase
  end

endmodule

FILE: rtl/kf_datapath.sv
// Datapath of the Kuwahara filter: counters, line store, quadrant statistics and divider.
module kf_datapath #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_RADIUS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  kf_pkg::kf_cmd_t                 cmd,
  output kf_pkg::kf_sts_t                 sts,
  input  logic                            cfg_we,
  input  logic [kf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                            in_operation,
  input  logic [kf_pkg::CHAN_W-1:0]       in_blue_in,
  input  logic [kf_pkg::CHAN_W-1:0]       in_green_in,
  input  logic [kf_pkg::CHAN_W-1:0]       in_red_in,
  input  logic [kf_pkg::CHAN_W-1:0]       in_alpha_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [kf_pkg::CHAN_W-1:0]       out_blue_out,
  output logic [kf_pkg::CHAN_W-1:0]       out_green_out,
  output logic [kf_pkg::CHAN_W-1:0]       out_red_out,
  output logic [kf_pkg::CHAN_W-1:0]       out_alpha_out,
  output logic                            out_last_of_frame
);

  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int RW     = $clog2(MAX_RADIUS + 1);
  localparam int DEPTH  = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
  localparam int AW     = $clog2(DEPTH);
  localparam int SZ_MAX = (MAX_RADIUS + 1) * (MAX_RADIUS + 1);
  localparam int SZW    = $clog2(SZ_MAX + 1);
  localparam int SUMW   = $clog2(SZ_MAX * 255 + 1);
  localparam int SV2W   = $clog2(SZ_MAX * 65025 + 1);
  localparam int VARW   = SZW + SV2W;
  localparam int TW     = SZW + 8;
  localparam int XS     = WW + 2;
  localparam int YS     = HW + 2;
  localparam int DYW    = RW + 2;
  localparam int PW     = DYW + WW + 1;
  localparam int RAW    = AW + 2;
  localparam int CW     = kf_pkg::CHAN_W;

  // Configuration registers and their clamped values.
  logic [kf_pkg::CFG_W_W-1:0] cfg_w_r;
  logic [kf_pkg::CFG_H_W-1:0] cfg_h_r;
  logic [kf_pkg::CFG_R_W-1:0] cfg_r_r;
  logic                       cfg_a_r;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [RW-1:0] r_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= kf_pkg::CFG_W_W'(1);
      cfg_h_r <= kf_pkg::CFG_H_W'(1);
      cfg_r_r <= '0;
      cfg_a_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kf_pkg::REG_IMAGE_WIDTH:   cfg_w_r <= cfg_data[kf_pkg::CFG_W_W-1:0];
        kf_pkg::REG_IMAGE_HEIGHT:  cfg_h_r <= cfg_data[kf_pkg::CFG_H_W-1:0];
        kf_pkg::REG_RADIUS:        cfg_r_r <= cfg_data[kf_pkg::CFG_R_W-1:0];
        kf_pkg::REG_AVERAGE_ALPHA: cfg_a_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_w_r == '0) w_eff = WW'(1);
    else if (32'(cfg_w_r) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(cfg_w_r);
    if (cfg_h_r == '0) h_eff = HW'(1);
    else if (32'(cfg_h_r) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(cfg_h_r);
    if (32'(cfg_r_r) > MAX_RADIUS) r_eff = RW'(MAX_RADIUS);
    else r_eff = RW'(cfg_r_r);
  end

  logic [SZW-1:0] size_r;
  logic [SZW-1:0] rp1;
  assign rp1 = SZW'(r_eff) + SZW'(1);
  always_ff @(posedge clk) begin
    size_r <= SZW'(rp1 * rp1);
  end

  // Frame position counters and ring addresses.
  logic [WW-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [HW-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [AW-1:0] in_addr_r, in_addr_nxt, out_base_r, out_base_nxt;
  logic          last_nxt;
  logic          restart, wr_en;
  logic [WW-1:0] ic;
  logic [HW-1:0] ir;
  logic [AW-1:0] ia;
  logic [AW:0]   base_sum;

  always_comb begin
    restart      = (in_row_r >= h_eff) && (out_row_r >= h_eff);
    ic           = restart ? '0 : in_col_r;
    ir           = restart ? '0 : in_row_r;
    ia           = restart ? '0 : in_addr_r;
    wr_en        = cmd.accept && (in_operation == kf_pkg::OP_PIXEL) && (ir < h_eff);
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    in_addr_nxt  = in_addr_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    out_base_nxt = out_base_r;
    base_sum     = (AW + 1)'(out_base_r) + (AW + 1)'(w_eff);
    last_nxt     = 1'b0;
    if (cmd.accept) begin
      in_col_nxt   = ic;
      in_row_nxt   = ir;
      in_addr_nxt  = ia;
      if (restart) begin
        out_col_nxt  = '0;
        out_row_nxt  = '0;
        out_base_nxt = '0;
      end
      if (wr_en) begin
        if (ic + WW'(1) >= w_eff) begin
          in_col_nxt = '0;
          in_row_nxt = ir + HW'(1);
        end else begin
          in_col_nxt = ic + WW'(1);
        end
        if (32'(ia) == DEPTH - 1) in_addr_nxt = '0;
        else in_addr_nxt = ia + AW'(1);
      end
    end
    if (cmd.load_out) begin
      if (out_col_r + WW'(1) >= w_eff) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + HW'(1);
        if (32'(base_sum) >= DEPTH) out_base_nxt = AW'(base_sum - (AW + 1)'(DEPTH));
        else out_base_nxt = AW'(base_sum);
      end else begin
        out_col_nxt = out_col_r + WW'(1);
      end
    end
    last_nxt = out_row_nxt >= h_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r   <= '0;
      in_row_r   <= '0;
      in_addr_r  <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      out_base_r <= '0;
    end else begin
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      in_addr_r  <= in_addr_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      out_base_r <= out_base_nxt;
    end
  end

  // Readiness of the next output position.
  logic [HW:0] nr_full;
  logic [WW:0] nc_full;
  logic [HW-1:0] nr;
  logic [WW-1:0] nc;
  logic          out_rdy;

  always_comb begin
    nr_full = (HW + 1)'(out_row_r) + (HW + 1)'(r_eff);
    nc_full = (WW + 1)'(out_col_r) + (WW + 1)'(r_eff);
    nr = (nr_full > (HW + 1)'(h_eff - HW'(1))) ? h_eff - HW'(1) : HW'(nr_full);
    nc = (nc_full > (WW + 1)'(w_eff - WW'(1))) ? w_eff - WW'(1) : WW'(nc_full);
    out_rdy = (out_row_r < h_eff) &&
              ((in_row_r >= h_eff) || (in_row_r > nr) ||
               ((in_row_r == nr) && (in_col_r > nc)));
  end

  // Tap sequencing over the four quadrants.
  logic [1:0]    q_r;
  logic [RW-1:0] dy_r, dx_r;
  logic          tap_last;

  assign tap_last = (dy_r == r_eff) && (dx_r == r_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r  <= '0;
      dy_r <= '0;
      dx_r <= '0;
    end else if (cmd.scan_init) begin
      q_r  <= '0;
      dy_r <= '0;
      dx_r <= '0;
    end else if (cmd.issue) begin
      if (dx_r == r_eff) begin
        dx_r <= '0;
        dy_r <= tap_last ? '0 : dy_r + RW'(1);
      end else begin
        dx_r <= dx_r + RW'(1);
      end
    end else if (cmd.var_cmp) begin
      q_r <= q_r + 2'd1;
    end
  end

  // Address pipeline: clamp and row offset, row address, column add, memory read.
  logic signed [YS-1:0]  yv;
  logic signed [XS-1:0]  xv;
  logic [HW-1:0]         rowc;
  logic [WW-1:0]         colc;
  logic signed [YS-1:0]  dy_full;
  logic signed [DYW-1:0] dyc;
  logic signed [PW-1:0]  prod_c;
  logic signed [RAW-1:0] rs;
  logic [AW:0]           asum;
  logic [AW-1:0]         raddr;
  logic [kf_pkg::PIXEL_W-1:0] rdata;

  logic signed [PW-1:0] p0_prod_r;
  logic [WW-1:0]        p0_col_r, p1_col_r;
  logic [AW-1:0]        p1_row_r;
  logic                 v0_r, v1_r, v2_r;
  logic                 t0_r, t1_r, t2_r;

  always_comb begin
    yv = $signed(YS'(out_row_r)) + $signed(YS'(dy_r)) -
         (q_r[1] ? $signed(YS'(0)) : $signed(YS'(r_eff)));
    xv = $signed(XS'(out_col_r)) + $signed(XS'(dx_r)) -
         (q_r[0] ? $signed(XS'(0)) : $signed(XS'(r_eff)));
    if (yv < 0) rowc = '0;
    else if (yv > $signed(YS'(h_eff)) - $signed(YS'(1))) rowc = h_eff - HW'(1);
    else rowc = HW'(yv);
    if (xv < 0) colc = '0;
    else if (xv > $signed(XS'(w_eff)) - $signed(XS'(1))) colc = w_eff - WW'(1);
    else colc = WW'(xv);
    dy_full = $signed(YS'(rowc)) - $signed(YS'(out_row_r));
    dyc     = DYW'(dy_full);
    prod_c  = PW'(dyc) * PW'($signed({1'b0, w_eff}));
    rs = $signed(RAW'(out_base_r)) + RAW'(p0_prod_r);
    if (rs < 0) rs = rs + $signed(RAW'(DEPTH));
    else if (rs >= $signed(RAW'(DEPTH))) rs = rs - $signed(RAW'(DEPTH));
    asum = (AW + 1)'(p1_row_r) + (AW + 1)'(p1_col_r);
    if (32'(asum) >= DEPTH) raddr = AW'(asum - (AW + 1)'(DEPTH));
    else raddr = AW'(asum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= cmd.issue;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
    p0_prod_r <= prod_c;
    p0_col_r  <= colc;
    t0_r      <= (q_r == 2'd3) && (dy_r == '0) && (dx_r == '0);
    p1_row_r  <= AW'(rs);
    p1_col_r  <= p0_col_r;
    t1_r      <= t0_r;
    t2_r      <= t1_r;
  end

  kf_ram #(
    .WIDTH (kf_pkg::PIXEL_W),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (ia),
    .wdata ({in_alpha_in, in_red_in, in_green_in, in_blue_in}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Quadrant statistics.
  logic [SUMW-1:0] sum_r [4];
  logic [SUMW-1:0] sv_r;
  logic [SV2W-1:0] sv2_r;
  logic [CW-1:0]   vmax, vrg;
  logic [15:0]     vsq;
  logic [CW-1:0]   center_alpha_r;
  logic [VARW-1:0] prod_a_r, prod_b_r, best_r, var_c;
  logic [SUMW-1:0] bsum_r [4];
  logic [CW-1:0]   quo_r [4];
  logic [TW-1:0]   trial_r;
  logic [2:0]      div_i_r;

  always_comb begin
    vrg  = (rdata[23:16] > rdata[15:8]) ? rdata[23:16] : rdata[15:8];
    vmax = (rdata[7:0] > vrg) ? rdata[7:0] : vrg;
    vsq  = 16'(vmax) * 16'(vmax);
    var_c = prod_a_r - prod_b_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init || cmd.var_cmp) begin
      for (int k = 0; k < 4; k++) sum_r[k] <= '0;
      sv_r  <= '0;
      sv2_r <= '0;
    end else if (v2_r) begin
      for (int k = 0; k < 4; k++) begin
        sum_r[k] <= sum_r[k] + SUMW'(rdata[CW*k +: CW]);
      end
      sv_r  <= sv_r + SUMW'(vmax);
      sv2_r <= sv2_r + SV2W'(vsq);
    end
    if (v2_r && t2_r) center_alpha_r <= rdata[31:24];
    if (cmd.var_mul) begin
      prod_a_r <= VARW'(size_r) * VARW'(sv2_r);
      prod_b_r <= VARW'(sv_r) * VARW'(sv_r);
    end
    if (cmd.var_cmp) begin
      if ((q_r == 2'd0) || (var_c < best_r)) begin
        best_r <= var_c;
        for (int k = 0; k < 4; k++) bsum_r[k] <= sum_r[k];
      end
      for (int k = 0; k < 4; k++) quo_r[k] <= '0;
      trial_r <= TW'(size_r) << 7;
      div_i_r <= 3'd7;
    end else if (cmd.div_step) begin
      for (int k = 0; k < 4; k++) begin
        if (TW'(bsum_r[k]) >= trial_r) begin
          bsum_r[k]          <= SUMW'(TW'(bsum_r[k]) - trial_r);
          quo_r[k][div_i_r]  <= 1'b1;
        end
      end
      trial_r <= trial_r >> 1;
      div_i_r <= div_i_r - 3'd1;
    end
  end

  // Output register.
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.load_out) begin
      out_blue_out      <= quo_r[0];
      out_green_out     <= quo_r[1];
      out_red_out       <= quo_r[2];
      out_alpha_out     <= cfg_a_r ? quo_r[3] : center_alpha_r;
      out_last_of_frame <= last_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign sts.out_ready = out_rdy;
  assign sts.tap_last  = tap_last;
  assign sts.pipe_busy = v0_r || v1_r || v2_r;
  assign sts.q_last    = (q_r == 2'd3);
  assign sts.div_last  = (div_i_r == 3'd0);
  assign sts.out_free  = !out_valid_r || !out_stall;

endmodule

FILE: rtl/kuwahara_filter.sv
// Kuwahara filter over a raster-order BGRA frame, one item at a time.
// Each item either supplies a source pixel or drains a pending output and
// yields at most one result. An item that releases no output passes only
// through the idle and check states. One that releases a result scans,
// drains and compares each of the four quadrants, then divides; its result
// may wait on out_stall. Every tap is one read of the line store per cycle,
// and the quadrant means come from an eight-step shared divider.
// Configuration is written only while the block is idle; cfg_ready shows it.
module kuwahara_filter #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_RADIUS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic [kf_pkg::CHAN_W-1:0]     in_blue_in,
  input  logic [kf_pkg::CHAN_W-1:0]     in_green_in,
  input  logic [kf_pkg::CHAN_W-1:0]     in_red_in,
  input  logic [kf_pkg::CHAN_W-1:0]     in_alpha_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kf_pkg::CHAN_W-1:0]     out_blue_out,
  output logic [kf_pkg::CHAN_W-1:0]     out_green_out,
  output logic [kf_pkg::CHAN_W-1:0]     out_red_out,
  output logic [kf_pkg::CHAN_W-1:0]     out_alpha_out,
  output logic                          out_last_of_frame,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kf_pkg::CFG_DATA_W-1:0] cfg_data
);

  kf_pkg::kf_cmd_t cmd;
  kf_pkg::kf_sts_t sts;
  logic            idle;

  kf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .idle     (idle)
  );

  kf_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_operation      (in_operation),
    .in_blue_in        (in_blue_in),
    .in_green_in       (in_green_in),
    .in_red_in         (in_red_in),
    .in_alpha_in       (in_alpha_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_blue_out      (out_blue_out),
    .out_green_out     (out_green_out),
    .out_red_out       (out_red_out),
    .out_alpha_out     (out_alpha_out),
    .out_last_of_frame (out_last_of_frame)
  );

  assign in_stall  = !idle;
  assign cfg_ready = idle;

endmodule

FILE: rtl/kf_checker.sv
// Port-level checker of the Kuwahara filter and its bind statement.
`include "kuwahara_filter_macros.svh"

module kf_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [kf_pkg::CHAN_W-1:0] out_blue_out,
  input logic [kf_pkg::CHAN_W-1:0] out_alpha_out,
  input logic                      cfg_ready
);

  `KF_ASSERT_NEXT(a_busy_after_item, clk, rst_n, in_valid && !in_stall, in_stall)
  `KF_ASSERT_SAME(a_cfg_only_idle, clk, rst_n, cfg_ready, !in_stall)
  `KF_ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && out_stall, out_valid)
  `KF_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_blue_out) && $stable(out_alpha_out))

endmodule

bind kuwahara_filter kf_checker u_kf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_blue_out  (out_blue_out),
  .out_alpha_out (out_alpha_out),
  .cfg_ready     (cfg_ready)
);
